>>> rtl/pww_pkg.sv
// Package for the proportional word wrap block.
// Holds the glyph width table, character and register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pww_pkg;

	localparam int WORD_MAX_DEF = 32;
	localparam int LINE_PX_W    = 18;
	localparam int WORD_PX_W    = 9;
	localparam int CNT_W        = 16;
	localparam int CFG_W        = 16;

	localparam logic [CFG_W-1:0] LINE_LIMIT_RST = 16'd160;
	localparam logic [CFG_W-1:0] OUT_CAP_RST    = 16'd1024;

	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [7:0] CHR_SP = 8'h20;

	localparam logic [3:0] SPACE_PX = 4'd4;

	// register indexes on the config port
	localparam logic CFG_LINE_LIMIT = 1'b0;
	localparam logic CFG_OUT_CAP    = 1'b1;

	localparam logic [3:0] GLYPH_PX [128] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2,
		4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
		4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
		4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
		4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10,
		4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
		4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
		4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEP,
		S_RD,
		S_CH,
		S_EOL,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

>>> rtl/proportional_word_wrap.sv
// Greedy word wrap over a proportional font, one text byte per input item.
// Uses pww_pkg for the glyph table, codes and state type.
//
// Channels: input items (kind, character) on in_valid/in_ready, results
// (out_char, has_char, final_res, lines, word_clipped) on out_valid/out_ready,
// register writes (cfg_index, cfg_data) on cfg_valid/cfg_ready, always ready.
// A word byte is stored while the block stays idle, so in_ready stays high.
// A space, CR/LF or end item flushes the buffered word through the single
// registered read port of the word memory: the separator decision, then for
// each word byte a memory read and an output load, then the line end and,
// for an end item, the closing result. Bytes stall one for one while the
// output register is held by the receiver; a stalled receiver only freezes
// the sequencer, nothing is dropped. in_ready is low while a flush runs.
// The end item gives the closing result and clears all stream state.
// Reset restores line_limit 160, output_capacity 1024 and empty stream state;
// the word memory needs no clearing since only bytes of the current word are read.
`timescale 1ns / 1ps
`default_nettype none
module proportional_word_wrap
	import pww_pkg::*;
#(
	parameter int WORD_MAX = WORD_MAX_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             kind,
	input  wire logic [7:0]       character,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_char,
	output logic                  has_char,
	output logic                  final_res,
	output logic [CNT_W-1:0]      lines,
	output logic                  word_clipped,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int LW = $clog2(WORD_MAX + 1);
	localparam int IW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]     line_limit_q, out_cap_q;
	logic [7:0]           word_mem [WORD_MAX];
	logic [7:0]           rd_q;
	logic [LW-1:0]        len_q;
	logic [IW-1:0]        idx_q;
	logic [WORD_PX_W-1:0] wpx_q;
	logic [LINE_PX_W-1:0] lpx_q;
	logic                 started_q, clip_q, eol_q, fin_q;
	logic [CNT_W-1:0]     ltot_q, emitted_q;

	logic                 out_valid_q, has_char_q, final_q, clip_out_q;
	logic [7:0]           out_char_q;
	logic [CNT_W-1:0]     lines_q;

	logic                 acc_in, slot_free, is_eol_chr, store_en, store_room;
	logic                 emit_en, sep_nl, word_done, line_nl, fin_load, next_rd;
	logic [7:0]           emit_ch;
	logic [CFG_W-1:0]     cap_eff;
	logic                 cap_ok;
	logic [LINE_PX_W:0]   fit_sum;
	logic                 too_wide;
	logic [WORD_PX_W:0]   wpx_sum;
	logic [3:0]           glyph;

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign acc_in       = in_valid && in_ready;
	assign slot_free    = !out_valid_q || out_ready;
	assign is_eol_chr   = (character == CHR_CR) || (character == CHR_LF);
	assign store_room   = (len_q < LW'(WORD_MAX));
	assign store_en     = acc_in && !kind && !is_eol_chr && (character != CHR_SP);
	assign cap_eff      = (out_cap_q == '0) ? CFG_W'(1) : out_cap_q;
	assign cap_ok       = ({1'b0, emitted_q} + 17'd1) < {1'b0, cap_eff};
	assign fit_sum      = {1'b0, lpx_q} + (LINE_PX_W + 1)'(wpx_q);
	assign too_wide     = fit_sum > (LINE_PX_W + 1)'(line_limit_q);
	assign glyph        = character[7] ? 4'd0 : GLYPH_PX[character[6:0]];
	assign wpx_sum      = {1'b0, wpx_q} + (WORD_PX_W + 1)'(glyph);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit_en   = 1'b0;
		emit_ch   = CHR_SP;
		sep_nl    = 1'b0;
		word_done = 1'b0;
		line_nl   = 1'b0;
		fin_load  = 1'b0;
		next_rd   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in && (kind || is_eol_chr || character == CHR_SP)) begin
					state_d = S_SEP;
				end
			end
			S_SEP: begin
				if (len_q == '0) begin
					state_d = S_EOL;
				end else if (lpx_q == '0) begin
					state_d = S_RD;
				end else if (slot_free) begin
					emit_en = 1'b1;
					sep_nl  = too_wide;
					emit_ch = too_wide ? CHR_LF : CHR_SP;
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_CH;
			end
			S_CH: begin
				if (slot_free) begin
					emit_en = 1'b1;
					emit_ch = rd_q;
					if (LW'(idx_q) + LW'(1) == len_q) begin
						word_done = 1'b1;
						state_d   = S_EOL;
					end else begin
						next_rd = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_EOL: begin
				if (!eol_q) begin
					state_d = S_IDLE;
				end else if (!started_q) begin
					state_d = fin_q ? S_FIN : S_IDLE;
				end else if (slot_free) begin
					emit_en = 1'b1;
					emit_ch = CHR_LF;
					line_nl = 1'b1;
					state_d = fin_q ? S_FIN : S_IDLE;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					fin_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_en && store_room) begin
			word_mem[len_q[IW-1:0]] <= character;
		end
		rd_q <= word_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LINE_LIMIT_RST;
			out_cap_q    <= OUT_CAP_RST;
			len_q        <= '0;
			idx_q        <= '0;
			wpx_q        <= '0;
			lpx_q        <= '0;
			started_q    <= 1'b0;
			clip_q       <= 1'b0;
			eol_q        <= 1'b0;
			fin_q        <= 1'b0;
			ltot_q       <= '0;
			emitted_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LINE_LIMIT: line_limit_q <= cfg_data;
					CFG_OUT_CAP:    out_cap_q    <= cfg_data;
				endcase
			end

			if (acc_in) begin
				eol_q <= kind || is_eol_chr;
				fin_q <= kind;
				if (!kind && !is_eol_chr) begin
					started_q <= 1'b1;
				end
			end

			if (store_en) begin
				if (store_room) begin
					len_q <= len_q + LW'(1);
					wpx_q <= wpx_sum[WORD_PX_W] ? '1 : wpx_sum[WORD_PX_W-1:0];
				end else begin
					clip_q <= 1'b1;
				end
			end

			if (state_q == S_SEP) begin
				idx_q <= '0;
			end else if (next_rd) begin
				idx_q <= idx_q + IW'(1);
			end

			if (sep_nl || line_nl) begin
				if (ltot_q != '1) begin
					ltot_q <= ltot_q + CNT_W'(1);
				end
			end
			if (sep_nl || line_nl) begin
				lpx_q <= '0;
			end else if (word_done) begin
				lpx_q <= lpx_q + LINE_PX_W'(wpx_q) + LINE_PX_W'(SPACE_PX);
			end
			if (line_nl) begin
				started_q <= 1'b0;
			end
			if (word_done) begin
				len_q <= '0;
				wpx_q <= '0;
			end

			if (emit_en && cap_ok) begin
				emitted_q <= emitted_q + CNT_W'(1);
			end

			if ((emit_en && cap_ok) || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// end of text: back to a fresh stream
			if (fin_load) begin
				len_q     <= '0;
				wpx_q     <= '0;
				lpx_q     <= '0;
				started_q <= 1'b0;
				ltot_q    <= '0;
				emitted_q <= '0;
				clip_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_char_q <= 8'd0;
			has_char_q <= 1'b0;
			final_q    <= 1'b1;
			lines_q    <= ltot_q;
			clip_out_q <= clip_q;
		end else if (emit_en && cap_ok) begin
			out_char_q <= emit_ch;
			has_char_q <= 1'b1;
			final_q    <= 1'b0;
			lines_q    <= '0;
			clip_out_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign has_char     = has_char_q;
	assign final_res    = final_q;
	assign lines        = lines_q;
	assign word_clipped = clip_out_q;

endmodule
`default_nettype wire

>>> rtl/pww_checker.sv
// Port-level checks for proportional_word_wrap, attached by bind.
// Uses pww_pkg for widths only.
`timescale 1ns / 1ps
`default_nettype none
module pww_checker
	import pww_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             kind,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [7:0]       out_char,
	input wire logic             has_char,
	input wire logic             final_res,
	input wire logic [CNT_W-1:0] lines,
	input wire logic             word_clipped
);

	// an end item always starts a flush, so the input side closes
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> !in_ready)
		else $error("input still ready after end item");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_char != final_res))
		else $error("item is neither a character nor the closing one");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_char |-> (lines == '0) && !word_clipped)
		else $error("character item carries summary fields");

	a_fin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_res |-> (out_char == 8'd0))
		else $error("closing item carries a character");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(final_res))
		else $error("stalled output item changed");

endmodule

bind proportional_word_wrap pww_checker u_pww_checker (.*);
`default_nettype wire

>>> sim/tb_proportional_word_wrap.sv
// Self-checking bench for proportional_word_wrap: random and directed text streams,
// predicted wrapped output compared item by item. Depends on pww_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_proportional_word_wrap;
	import pww_pkg::*;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int SETTLE_CYCLES  = 2 * WORD_MAX_DEF + 16;
	localparam int LONG_HOLD      = 400;

	localparam logic [3:0] GLYPH_WIDTH [128] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2, 4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
		4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
		4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
		4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10, 4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
		4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} text_item_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic             has;
		logic             fin;
		logic [CNT_W-1:0] cnt;
		logic             clip;
	} wrap_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             kind = KIND_TEXT;
	logic [7:0]       character = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       out_char;
	logic             has_char;
	logic             final_res;
	logic [CNT_W-1:0] lines;
	logic             word_clipped;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = CFG_LINE_LIMIT;
	logic [CFG_W-1:0] cfg_data = '0;

	proportional_word_wrap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.character    (character),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.has_char     (has_char),
		.final_res    (final_res),
		.lines        (lines),
		.word_clipped (word_clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_item_t   source_text_q[$];
	wrap_result_t wrapped_text_q[$];

	int queued_cnt    = 0;
	int in_sent_cnt   = 0;
	int in_taken_cnt  = 0;
	int mismatch_cnt  = 0;
	int cycle_cnt     = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;

	// predicted block state
	logic [CFG_W-1:0]     line_limit_q = LINE_LIMIT_RST;
	logic [CFG_W-1:0]     out_cap_q    = OUT_CAP_RST;
	logic [7:0]           word_buf [WORD_MAX_DEF];
	logic [5:0]           word_len  = '0;
	logic [WORD_PX_W-1:0] word_px   = '0;
	logic [LINE_PX_W-1:0] line_px   = '0;
	logic                 line_open = 1'b0;
	logic [CNT_W-1:0]     line_cnt  = '0;
	logic [CNT_W-1:0]     sent_cnt  = '0;
	logic                 clip_flag = 1'b0;

	task automatic emit_byte(input logic [7:0] b);
		wrap_result_t r;
		int cap;
		cap = (out_cap_q == 0) ? 1 : int'(out_cap_q);
		if (int'(sent_cnt) + 1 < cap) begin
			sent_cnt++;
			r = '0;
			r.ch = b;
			r.has = 1'b1;
			wrapped_text_q.push_back(r);
		end
	endtask

	task automatic bump_lines();
		if (line_cnt != '1)
			line_cnt++;
	endtask

	task automatic flush_word();
		int i;
		if (word_len != 0) begin
			if (line_px != 0) begin
				if (int'(line_px) + int'(word_px) > int'(line_limit_q)) begin
					emit_byte(CHR_LF);
					line_px = '0;
					bump_lines();
				end else begin
					emit_byte(CHR_SP);
				end
			end
			for (i = 0; i < int'(word_len); i++)
				emit_byte(word_buf[i]);
			line_px = line_px + LINE_PX_W'(word_px) + LINE_PX_W'(SPACE_PX);
			word_len = '0;
			word_px = '0;
		end
	endtask

	task automatic close_line();
		if (line_open) begin
			emit_byte(CHR_LF);
			bump_lines();
			line_px = '0;
			line_open = 1'b0;
		end
	endtask

	task automatic advance_wrap(input logic k, input logic [7:0] c);
		wrap_result_t r;
		int w;
		if (k == KIND_END) begin
			flush_word();
			close_line();
			r = '0;
			r.fin = 1'b1;
			r.cnt = line_cnt;
			r.clip = clip_flag;
			wrapped_text_q.push_back(r);
			word_len = '0;
			word_px = '0;
			line_px = '0;
			line_open = 1'b0;
			line_cnt = '0;
			sent_cnt = '0;
			clip_flag = 1'b0;
		end else if (c == CHR_CR || c == CHR_LF) begin
			flush_word();
			close_line();
		end else if (c == CHR_SP) begin
			line_open = 1'b1;
			flush_word();
		end else begin
			line_open = 1'b1;
			if (int'(word_len) < WORD_MAX_DEF) begin
				word_buf[word_len[4:0]] = c;
				word_len++;
				w = int'(word_px) + (c[7] ? 0 : int'(GLYPH_WIDTH[c[6:0]]));
				word_px = (w > 511) ? 9'd511 : WORD_PX_W'(w);
			end else begin
				clip_flag = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// results are checked and accepted inputs predicted at the rising edge
	always @(posedge clk) begin : result_monitor
		wrap_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (wrapped_text_q.size() == 0) begin
					$display("%0t ns: expected no item, got char %0d has %0d final %0d lines %0d clip %0d",
						$time, out_char, has_char, final_res, lines, word_clipped);
					mismatch_cnt++;
				end else begin
					want = wrapped_text_q.pop_front();
					check_field("out_char", 16'(want.ch), 16'(out_char));
					check_field("has_char", 16'(want.has), 16'(has_char));
					check_field("final_res", 16'(want.fin), 16'(final_res));
					check_field("lines", want.cnt, lines);
					check_field("word_clipped", 16'(want.clip), 16'(word_clipped));
				end
			end
			if (in_valid && in_ready) begin
				advance_wrap(kind, character);
				in_taken_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LINE_LIMIT)
					line_limit_q = cfg_data;
				else
					out_cap_q = cfg_data;
			end
		end
	end

	always @(negedge clk) begin : text_driver
		logic offer;
		text_item_t nxt;
		if (arst_n) begin
			offer = in_valid;
			// item went in at the last rising edge
			if (in_valid && in_taken_cnt == in_sent_cnt)
				offer = 1'b0;
			if (!offer && source_text_q.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				nxt = source_text_q.pop_front();
				kind <= nxt.kind;
				character <= nxt.ch;
				in_sent_cnt++;
				offer = 1'b1;
			end
			in_valid <= offer;
		end
	end

	always @(negedge clk) begin : result_sink
		int hold_left;
		int hold_served;
		if (arst_n) begin
			if (hold_served != hold_req) begin
				hold_left = LONG_HOLD;
				hold_served = hold_req;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
		$display("FAILURE");
		$finish;
	end

	task automatic push_item(input logic k, input logic [7:0] c);
		text_item_t it;
		it.kind = k;
		it.ch = c;
		source_text_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic push_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_item(KIND_TEXT, s[i]);
	endtask

	// words of printable bytes, space runs, CR/LF runs, stray bytes, then end item
	task automatic gen_text(input int n_chars, input bit long_word);
		int produced;
		int wl;
		int r;
		int j;
		produced = 0;
		while (produced < n_chars) begin
			r = $urandom_range(99);
			if (r < 8) begin
				push_item(KIND_TEXT, 8'($urandom_range(255)));
				produced++;
			end else begin
				wl = (long_word || r < 10) ? $urandom_range(33, 40) : $urandom_range(1, 7);
				long_word = 1'b0;
				for (j = 0; j < wl; j++)
					push_item(KIND_TEXT, 8'($urandom_range(33, 126)));
				produced += wl;
				r = $urandom_range(99);
				if (r < 65) begin
					wl = $urandom_range(1, 2);
				end else if (r < 85) begin
					wl = $urandom_range(1, 3);
					for (j = 0; j < wl; j++)
						push_item(KIND_TEXT, $urandom_range(1) ? CHR_CR : CHR_LF);
					wl = 0;
				end else if (r < 93) begin
					push_item(KIND_TEXT, CHR_LF);
					wl = $urandom_range(1, 3);
					produced++;
				end else begin
					wl = 0;
				end
				for (j = 0; j < wl; j++)
					push_item(KIND_TEXT, CHR_SP);
				produced += wl;
			end
		end
		push_item(KIND_END, 8'($urandom_range(255)));
	endtask

	task automatic fill_items(input int n, input bit long_first);
		int start;
		start = queued_cnt;
		while (queued_cnt - start < n) begin
			gen_text($urandom_range(10, 40), long_first);
			long_first = 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (source_text_q.size() != 0 || in_taken_cnt != in_sent_cnt
				|| wrapped_text_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one write: valid from a falling edge until the rising edge that takes it
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_LINE_LIMIT, LINE_LIMIT_RST);
		write_reg(CFG_OUT_CAP, OUT_CAP_RST);

		// space-only line, skipped empty line, zero-width bytes, double space
		push_item(KIND_TEXT, CHR_SP);
		push_item(KIND_TEXT, CHR_LF);
		push_item(KIND_TEXT, CHR_CR);
		push_item(KIND_TEXT, CHR_LF);
		push_string("Aa");
		push_item(KIND_TEXT, 8'h00);
		push_item(KIND_TEXT, 8'h09);
		push_item(KIND_TEXT, 8'hFF);
		push_item(KIND_TEXT, 8'h80);
		push_item(KIND_TEXT, 8'h7F);
		push_item(KIND_TEXT, CHR_SP);
		push_item(KIND_TEXT, CHR_SP);
		push_string("W~");
		push_item(KIND_TEXT, CHR_CR);
		push_item(KIND_END, 8'h00);
		push_item(KIND_END, 8'hFF);
		wait_drained();

		// narrow lines, no idling, first text carries an over-long word
		write_reg(CFG_LINE_LIMIT, 16'd40);
		fill_items(30, 1'b1);
		wait_drained();

		// zero line limit, widest output buffer, sender gaps
		send_idle_pct = 66;
		write_reg(CFG_LINE_LIMIT, 16'h0000);
		write_reg(CFG_OUT_CAP, 16'hFFFF);
		fill_items(25, 1'b0);
		wait_drained();

		// receiver stalls plus one long hold-off while items keep coming
		send_idle_pct = 0;
		recv_stall_pct = 66;
		write_reg(CFG_LINE_LIMIT, 16'hFFFF);
		write_reg(CFG_OUT_CAP, 16'd1024);
		hold_req++;
		fill_items(15, 1'b0);
		wait_drained();
		write_reg(CFG_OUT_CAP, 16'd25);
		fill_items(15, 1'b0);
		wait_drained();

		// nothing but closing items come out
		send_idle_pct = 35;
		recv_stall_pct = 35;
		write_reg(CFG_LINE_LIMIT, 16'd12);
		write_reg(CFG_OUT_CAP, 16'd0);
		fill_items(10, 1'b0);
		wait_drained();
		write_reg(CFG_OUT_CAP, 16'd1);
		fill_items(10, 1'b0);
		wait_drained();

		write_reg(CFG_LINE_LIMIT, 16'($urandom_range(8, 120)));
		write_reg(CFG_OUT_CAP, 16'($urandom_range(30, 300)));
		fill_items(25, 1'b0);
		wait_drained();

		if (mismatch_cnt == 0 && wrapped_text_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
